/* src/ghse_pkg.sv */
// ----------------------------------------------------------------------------
// ghse_pkg: shared constants of the grow/hold/shrink envelope
// Q16 level format, request and register codes, serial step counts.
// ----------------------------------------------------------------------------
`default_nettype none

package ghse_pkg;

  // Default widths handed to the top level parameters
  localparam int TIME_BITS_DEF = 24;
  localparam int SIZE_BITS_DEF = 16;

  // Q16 level: 17 bits, 65536 means one
  localparam int Q_BITS     = 16;
  localparam int LEVEL_BITS = Q_BITS + 1;
  localparam logic [LEVEL_BITS-1:0] ONE_Q16 = LEVEL_BITS'(1) << Q_BITS;

  // Step field of the input item
  localparam int STEP_BITS = 16;

  // Serial units produce one quotient or multiplier bit per cycle
  localparam int SERIAL_STEPS = LEVEL_BITS;
  localparam int CNT_BITS     = $clog2(SERIAL_STEPS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(SERIAL_STEPS - 1);

  // Configuration port
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_GROW_TIME    = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLD_TIME    = 4'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SHRINK_TIME  = 4'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FULL_SIZE_X  = 4'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FULL_SIZE_Y  = 4'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FULL_SIZE_Z  = 4'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PEAK_OPACITY = 4'd6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OPACITY_ON   = 4'd7;

  // Request kinds carried on tuser
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

endpackage : ghse_pkg

`default_nettype wire

/* src/ghse_div.sv */
// ----------------------------------------------------------------------------
// ghse_div: bit-serial restoring divider
// Computes (num << 16) / den for num <= den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ghse_div
  import ghse_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [TIME_BITS-1:0]  num,
  input  wire logic [TIME_BITS-1:0]  den,
  output logic                       done,
  output logic [LEVEL_BITS-1:0]      quo
);

  logic                 busy;
  logic [CNT_BITS-1:0]  cnt;
  logic [TIME_BITS:0]   rem;
  logic [TIME_BITS-1:0] den_r;
  logic                 ge;
  logic [TIME_BITS:0]   rem_sub;

  // Trial subtract; remainder stays below the divisor after it
  assign ge      = rem >= {1'b0, den_r};
  assign rem_sub = ge ? (rem - {1'b0, den_r}) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_BITS'(1);
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, num};
      den_r <= den;
      quo   <= '0;
    end else if (busy) begin
      rem <= {rem_sub[TIME_BITS-1:0], 1'b0};
      quo <= {quo[LEVEL_BITS-2:0], ge};
    end
  end

endmodule : ghse_div

`default_nettype wire

/* src/ghse_mul.sv */
// ----------------------------------------------------------------------------
// ghse_mul: bit-serial shift-add multiplier
// Computes (a * b) >> 16 for a 17-bit b, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ghse_mul
  import ghse_pkg::*;
#(
  parameter int A_BITS = LEVEL_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [A_BITS-1:0]      a,
  input  wire logic [LEVEL_BITS-1:0]  b,
  output logic                        done,
  output logic [A_BITS:0]             prod
);

  logic                  busy;
  logic [CNT_BITS-1:0]   cnt;
  logic [A_BITS-1:0]     a_r;
  logic [A_BITS:0]       hi;
  logic [LEVEL_BITS-1:0] lo;
  logic [A_BITS:0]       sum;

  // Add the multiplicand under the current multiplier bit
  assign sum  = hi + (lo[0] ? {1'b0, a_r} : '0);
  assign prod = {hi[A_BITS-1:0], lo[LEVEL_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_BITS'(1);
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      hi  <= '0;
      lo  <= b;
    end else if (busy) begin
      hi <= {1'b0, sum[A_BITS:1]};
      lo <= {sum[0], lo[LEVEL_BITS-1:1]};
    end
  end

endmodule : ghse_mul

`default_nettype wire

/* src/grow_hold_shrink_envelope.sv */
// ----------------------------------------------------------------------------
// grow_hold_shrink_envelope: grow/hold/shrink level driving size and opacity
// Bit-serial divider and shift-add multipliers evaluate the Q16 level curve.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_ channel. s_tuser picks the request: start
//   clears elapsed time and plays from zero, tick adds s_tdata time units.
//   Each start, and each tick while playing, yields one result item on the
//   m_ channel; a tick while idle yields none. m_tlast marks the result that
//   ends the envelope, after which the block is idle again.
//   Registers are written on the cfg_ channel, one per handshake; cfg_ready
//   is always high. The user must write them only while no item is in
//   flight; the block itself does not enforce this.
// Steps per item: start runs the opacity and size pass alone; hold or
//   finish adds the phase decision before it; shrink adds the 17-step serial
//   divider and a square on the 17-step shift-add multiplier; grow, a cube.
//   One item is in flight at a time; the next item is taken the cycle after
//   the result is in the output register, even if that result still waits.
// Reset clears playing and elapsed time and loads register defaults
//   (durations and sizes zero, peak opacity one, opacity enabled).
// A stalled receiver holds the output register; the block finishes the
//   next item and then waits for the register to drain before accepting more.
// ----------------------------------------------------------------------------
`default_nettype none

module grow_hold_shrink_envelope
  import ghse_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,

  // Input items
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [STEP_BITS-1:0]        s_tdata,   // step_time
  input  wire logic                        s_tuser,   // req_type

  // Result items
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // size_x, size_y, size_z, opacity, level, zero fill
  output logic [((3*SIZE_BITS+2*LEVEL_BITS+7)/8)*8-1:0] m_tdata,
  output logic                             m_tlast,   // done_res

  // Register writes
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int ELAPSED_BITS = TIME_BITS + 2;
  localparam int SUM_BITS     = ((ELAPSED_BITS > STEP_BITS) ? ELAPSED_BITS : STEP_BITS) + 1;
  localparam int OUT_BITS     = 3 * SIZE_BITS + 2 * LEVEL_BITS;
  localparam int OUT_TDATA    = ((OUT_BITS + 7) / 8) * 8;
  localparam int LVL_LSB      = 3 * SIZE_BITS + LEVEL_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV,
    ST_SQUARE,
    ST_CUBE,
    ST_SCALE,
    ST_SEND
  } state_t;

  // Configuration registers
  logic [TIME_BITS-1:0]  grow_time;
  logic [TIME_BITS-1:0]  hold_time;
  logic [TIME_BITS-1:0]  shrink_time;
  logic [SIZE_BITS-1:0]  full_size_x;
  logic [SIZE_BITS-1:0]  full_size_y;
  logic [SIZE_BITS-1:0]  full_size_z;
  logic [LEVEL_BITS-1:0] peak_opacity;
  logic                  opacity_on;

  // Envelope state
  state_t                  state;
  logic                    playing;
  logic [ELAPSED_BITS-1:0] elapsed;
  logic [TIME_BITS:0]      hold_end;
  logic                    grow_phase;
  logic                    done_flag;
  logic [LEVEL_BITS-1:0]   level_r;
  logic [LEVEL_BITS-1:0]   frac_r;

  // Serial unit control
  logic                  div_start;
  logic [TIME_BITS-1:0]  div_num;
  logic [TIME_BITS-1:0]  div_den;
  logic                  div_done;
  logic [LEVEL_BITS-1:0] div_quo;
  logic                  mul_start;
  logic                  scale_start;
  logic [LEVEL_BITS-1:0] mul_a;
  logic [LEVEL_BITS-1:0] mul_b;
  logic                  mul_done;
  logic [LEVEL_BITS:0]   mul_prod;
  logic                  mul_y_done;
  logic                  mul_z_done;
  logic [SIZE_BITS:0]    prod_y;
  logic [SIZE_BITS:0]    prod_z;

  // Derived values
  logic                    s_accept;
  logic [SUM_BITS-1:0]     elapsed_sum;
  logic [ELAPSED_BITS-1:0] elapsed_sat;
  logic [ELAPSED_BITS-1:0] total;
  logic [ELAPSED_BITS-1:0] grow_left;
  logic [ELAPSED_BITS-1:0] shrink_in;
  logic                    in_grow;
  logic                    in_hold;
  logic                    in_shrink;
  logic [LEVEL_BITS-1:0]   peak_clamped;
  logic [LEVEL_BITS-1:0]   level_sq;
  logic [LEVEL_BITS-1:0]   level_cube;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign s_accept  = s_tvalid && s_tready;

  // Saturating add of the step to the elapsed time
  assign elapsed_sum = SUM_BITS'(elapsed) + SUM_BITS'(s_tdata);
  assign elapsed_sat = (elapsed_sum[SUM_BITS-1:ELAPSED_BITS] != '0)
                       ? '1 : elapsed_sum[ELAPSED_BITS-1:0];

  // Phase boundaries
  assign total     = ELAPSED_BITS'(hold_end) + ELAPSED_BITS'(shrink_time);
  assign grow_left = ELAPSED_BITS'(grow_time) - elapsed;
  assign shrink_in = elapsed - ELAPSED_BITS'(hold_end);
  assign in_grow   = (grow_time != '0) && (elapsed < ELAPSED_BITS'(grow_time));
  assign in_hold   = elapsed < ELAPSED_BITS'(hold_end);
  assign in_shrink = (shrink_time != '0) && (elapsed < total);

  // Treat a peak above one as one
  assign peak_clamped = peak_opacity[Q_BITS] ? ONE_Q16 : peak_opacity;

  // Levels out of the multiplier: 1 - f^2 and 1 - f^3 for the divider fraction f
  assign level_sq   = ONE_Q16 - mul_prod[LEVEL_BITS-1:0];
  assign level_cube = ONE_Q16 - mul_prod[LEVEL_BITS-1:0];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grow_time    <= '0;
      hold_time    <= '0;
      shrink_time  <= '0;
      full_size_x  <= '0;
      full_size_y  <= '0;
      full_size_z  <= '0;
      peak_opacity <= ONE_Q16;
      opacity_on   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GROW_TIME:    grow_time    <= cfg_data[TIME_BITS-1:0];
        CFG_HOLD_TIME:    hold_time    <= cfg_data[TIME_BITS-1:0];
        CFG_SHRINK_TIME:  shrink_time  <= cfg_data[TIME_BITS-1:0];
        CFG_FULL_SIZE_X:  full_size_x  <= cfg_data[SIZE_BITS-1:0];
        CFG_FULL_SIZE_Y:  full_size_y  <= cfg_data[SIZE_BITS-1:0];
        CFG_FULL_SIZE_Z:  full_size_z  <= cfg_data[SIZE_BITS-1:0];
        CFG_PEAK_OPACITY: peak_opacity <= cfg_data[LEVEL_BITS-1:0];
        CFG_OPACITY_ON:   opacity_on   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      playing     <= 1'b0;
      elapsed     <= '0;
      div_start   <= 1'b0;
      mul_start   <= 1'b0;
      scale_start <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      div_start   <= 1'b0;
      mul_start   <= 1'b0;
      scale_start <= 1'b0;
      // Drain the output register; a load in ST_SEND takes its place
      if (m_tvalid && m_tready && (state != ST_SEND)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_accept) begin
            if (s_tuser == REQ_START) begin
              // Restart from time zero and emit level zero
              elapsed     <= '0;
              playing     <= 1'b1;
              done_flag   <= 1'b0;
              level_r     <= '0;
              mul_a       <= peak_clamped;
              mul_b       <= '0;
              mul_start   <= 1'b1;
              scale_start <= 1'b1;
              state       <= ST_SCALE;
            end else if (playing) begin
              elapsed  <= elapsed_sat;
              hold_end <= {1'b0, grow_time} + {1'b0, hold_time};
              state    <= ST_DECIDE;
            end
          end
        end
        ST_DECIDE: begin
          if (in_grow) begin
            div_num    <= grow_left[TIME_BITS-1:0];
            div_den    <= grow_time;
            div_start  <= 1'b1;
            grow_phase <= 1'b1;
            state      <= ST_DIV;
          end else if (in_hold) begin
            done_flag   <= 1'b0;
            level_r     <= ONE_Q16;
            mul_a       <= peak_clamped;
            mul_b       <= ONE_Q16;
            mul_start   <= 1'b1;
            scale_start <= 1'b1;
            state       <= ST_SCALE;
          end else if (in_shrink) begin
            div_num    <= shrink_in[TIME_BITS-1:0];
            div_den    <= shrink_time;
            div_start  <= 1'b1;
            grow_phase <= 1'b0;
            state      <= ST_DIV;
          end else begin
            // Past the last phase: report the end and drop to idle
            playing     <= 1'b0;
            elapsed     <= '0;
            done_flag   <= 1'b1;
            level_r     <= '0;
            mul_a       <= peak_clamped;
            mul_b       <= '0;
            mul_start   <= 1'b1;
            scale_start <= 1'b1;
            state       <= ST_SCALE;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            frac_r    <= div_quo;
            mul_a     <= div_quo;
            mul_b     <= div_quo;
            mul_start <= 1'b1;
            state     <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          if (mul_done) begin
            if (grow_phase) begin
              mul_a     <= mul_prod[LEVEL_BITS-1:0];
              mul_b     <= frac_r;
              mul_start <= 1'b1;
              state     <= ST_CUBE;
            end else begin
              done_flag   <= 1'b0;
              level_r     <= level_sq;
              mul_a       <= peak_clamped;
              mul_b       <= level_sq;
              mul_start   <= 1'b1;
              scale_start <= 1'b1;
              state       <= ST_SCALE;
            end
          end
        end
        ST_CUBE: begin
          if (mul_done) begin
            done_flag   <= 1'b0;
            level_r     <= level_cube;
            mul_a       <= peak_clamped;
            mul_b       <= level_cube;
            mul_start   <= 1'b1;
            scale_start <= 1'b1;
            state       <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (mul_done) begin
            state <= ST_SEND;
          end
        end
        ST_SEND: begin
          // Load the output register once the previous item has drained
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tlast  <= done_flag;
            m_tdata  <= OUT_TDATA'({
                          level_r,
                          (opacity_on ? mul_prod[LEVEL_BITS-1:0] : {LEVEL_BITS{1'b0}}),
                          prod_z[SIZE_BITS-1:0],
                          prod_y[SIZE_BITS-1:0],
                          full_size_x});
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Shared divider for the grow and shrink fractions
  ghse_div #(
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Curve powers, then opacity scaling
  ghse_mul #(
    .A_BITS (LEVEL_BITS)
  ) u_mul_core (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Y and Z size scaling, run alongside the opacity pass
  ghse_mul #(
    .A_BITS (SIZE_BITS)
  ) u_mul_y (
    .clk   (clk),
    .rst   (rst),
    .start (scale_start),
    .a     (full_size_y),
    .b     (level_r),
    .done  (mul_y_done),
    .prod  (prod_y)
  );

  ghse_mul #(
    .A_BITS (SIZE_BITS)
  ) u_mul_z (
    .clk   (clk),
    .rst   (rst),
    .start (scale_start),
    .a     (full_size_z),
    .b     (level_r),
    .done  (mul_z_done),
    .prod  (prod_z)
  );

  // The size multipliers start with the opacity pass and finish with it
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCALE) && mul_done |-> mul_y_done && mul_z_done)
    else $error("size scaling out of step with opacity scaling");

  // The divider is launched only out of the phase decision
  assert property (@(posedge clk) disable iff (rst)
    div_start |-> $past(state == ST_DECIDE))
    else $error("divider started outside phase decision");

  // A level never exceeds one
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND) |-> (level_r <= ONE_Q16))
    else $error("level above one");

  // The closing item carries level zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> (m_tdata[LVL_LSB +: LEVEL_BITS] == '0))
    else $error("end-of-envelope item with nonzero level");

  // An accepted start leaves the block playing
  assert property (@(posedge clk) disable iff (rst)
    s_accept && (s_tuser == REQ_START) |=> playing)
    else $error("start did not set playing");

endmodule : grow_hold_shrink_envelope

`default_nettype wire
